// ===== rtl/rde_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the reversible deque engine
// no dependencies; used by the interfaces and all modules
package rde_pkg;

  localparam int ACTION_W = 3;
  localparam int FIELD_W  = 16;
  localparam int STATUS_W = 2;

  localparam int DEFAULT_DEPTH       = 64;
  localparam int DEFAULT_VALUE_WIDTH = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR   = 3'd0,
    ACT_LOAD    = 3'd1,
    ACT_REVERSE = 3'd2,
    ACT_DELETE  = 3'd3,
    ACT_READ    = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_ERROR      = 2'd1,
    ST_EMPTY_READ = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // request taken this cycle
    logic fetch;    // memory read data ready, load it into the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free; // result register empty or being emptied
    logic read_hit; // current request is a read that pops an element
  } stat_t;

endpackage

// ===== rtl/rde_in_if.sv =====
`timescale 1ns / 1ps
// request channel of the reversible deque engine
// depends on rde_pkg
interface rde_in_if;
  logic                         valid;
  logic                         ready;
  logic [rde_pkg::ACTION_W-1:0] action;
  logic [rde_pkg::FIELD_W-1:0]  value;

  modport source (output valid, action, value, input ready);
  modport sink (input valid, action, value, output ready);
endinterface

// ===== rtl/rde_out_if.sv =====
`timescale 1ns / 1ps
// result channel of the reversible deque engine
// depends on rde_pkg
interface rde_out_if;
  logic                         valid;
  logic                         ready;
  logic [rde_pkg::FIELD_W-1:0]  data;
  logic                         data_valid;
  logic                         last;
  logic [rde_pkg::STATUS_W-1:0] status;

  modport source (output valid, data, data_valid, last, status, input ready);
  modport sink (input valid, data, data_valid, last, status, output ready);
endinterface

// ===== rtl/reversible_deque_engine.sv =====
`timescale 1ns / 1ps
// top level of the reversible deque engine
// depends on rde_pkg, rde_in_if, rde_out_if, rde_controller, rde_datapath
//
// usage
//   req: one request per item, carrying action (clear, load, reverse,
//     delete front, read next) and value (used by load only)
//   rsp: exactly one result per request: data, data_valid, last, status
//   a request is taken on a rising edge with valid and ready both high
// result timing and throughput
//   clear, load, reverse, delete and every failing request: result is
//     registered, valid in the next cycle; one request per cycle while
//     rsp is ready; successful read: the element store has a registered
//     read port, and req is not ready during the fetch cycle
// stalls
//   a single result register separates the channels; a new request is
//   taken while the held result is being taken in the same cycle
// reset
//   synchronous, active high; the deque is empty, orientation normal,
//   sticky error clear; store contents are not cleared and need no sweep
module reversible_deque_engine #(
  parameter int DEPTH       = rde_pkg::DEFAULT_DEPTH,
  parameter int VALUE_WIDTH = rde_pkg::DEFAULT_VALUE_WIDTH
) (
  input logic       clk,
  input logic       rst,
  rde_in_if.sink    req,
  rde_out_if.source rsp
);

  rde_pkg::cmd_t  cmd;
  rde_pkg::stat_t stat;
  logic           ready;

  assign req.ready = ready;

  // sequencing: idle accepts, fetch waits on the memory read
  rde_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // ring store, pointers, flags and the result register
  rde_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .action (req.action),
    .value  (req.value),
    .rsp    (rsp)
  );

endmodule

// ===== rtl/rde_controller.sv =====
`timescale 1ns / 1ps
// request sequencing for the reversible deque engine
// depends on rde_pkg
module rde_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  rde_pkg::stat_t stat,
  output rde_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FETCH = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready  = (state == S_IDLE) && stat.out_free;
  assign cmd.accept = req_valid && req_ready;
  assign cmd.fetch  = (state == S_FETCH);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept && stat.read_hit) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/rde_datapath.sv =====
`timescale 1ns / 1ps
// ring buffer store, pointers, flags and result register
// depends on rde_pkg and rde_out_if
module rde_datapath #(
  parameter int DEPTH       = rde_pkg::DEFAULT_DEPTH,
  parameter int VALUE_WIDTH = rde_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rde_pkg::cmd_t                cmd,
  output rde_pkg::stat_t               stat,
  input  logic [rde_pkg::ACTION_W-1:0] action,
  input  logic [rde_pkg::FIELD_W-1:0]  value,
  rde_out_if.source                    rsp
);

  localparam int IW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int SW     = IW + 1;
  localparam int STOREW = (VALUE_WIDTH < rde_pkg::FIELD_W) ? VALUE_WIDTH : rde_pkg::FIELD_W;

  logic [STOREW-1:0] mem [DEPTH];
  logic [STOREW-1:0] rd_data;

  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic          reversed;
  logic          err;
  logic          last_pend;

  logic [IW-1:0] head_next;
  logic [CW-1:0] count_next;
  logic          reversed_next;
  logic          err_next;

  logic                 rsp_valid;
  logic [rde_pkg::FIELD_W-1:0] rsp_data;
  logic                 rsp_dv;
  logic                 rsp_last;
  rde_pkg::status_t     rsp_status;

  logic [SW-1:0] sum_back, sum_last, sum_inc;
  logic [IW-1:0] slot_back, slot_last, head_inc;
  logic          empty, full;
  logic          we, re, read_hit;
  rde_pkg::status_t res_status;

  // slot arithmetic, all sums stay below twice the depth except sum_last when empty
  always_comb begin
    sum_back  = SW'(head) + SW'(count);
    sum_last  = sum_back - SW'(1);
    sum_inc   = SW'(head) + SW'(1);
    slot_back = (sum_back >= SW'(DEPTH)) ? IW'(sum_back - SW'(DEPTH)) : IW'(sum_back);
    slot_last = (sum_last >= SW'(DEPTH)) ? IW'(sum_last - SW'(DEPTH)) : IW'(sum_last);
    head_inc  = (sum_inc >= SW'(DEPTH)) ? IW'(sum_inc - SW'(DEPTH)) : IW'(sum_inc);
    empty     = (count == '0);
    full      = (count == CW'(DEPTH));
  end

  // action decode
  always_comb begin
    head_next     = head;
    count_next    = count;
    reversed_next = reversed;
    err_next      = err;
    we            = 1'b0;
    re            = 1'b0;
    read_hit      = 1'b0;
    res_status    = rde_pkg::ST_OK;
    unique case (action)
      rde_pkg::ACT_CLEAR: begin
        head_next     = '0;
        count_next    = '0;
        reversed_next = 1'b0;
        err_next      = 1'b0;
      end
      rde_pkg::ACT_LOAD: begin
        if (err) begin
          res_status = rde_pkg::ST_ERROR;
        end else if (full) begin
          res_status = rde_pkg::ST_OVERFLOW;
        end else begin
          we         = 1'b1;
          count_next = count + CW'(1);
        end
      end
      rde_pkg::ACT_REVERSE: begin
        if (err) begin
          res_status = rde_pkg::ST_ERROR;
        end else begin
          reversed_next = ~reversed;
        end
      end
      rde_pkg::ACT_DELETE: begin
        if (err) begin
          res_status = rde_pkg::ST_ERROR;
        end else if (empty) begin
          err_next   = 1'b1;
          res_status = rde_pkg::ST_ERROR;
        end else begin
          count_next = count - CW'(1);
          if (!reversed) begin
            head_next = head_inc;
          end
        end
      end
      rde_pkg::ACT_READ: begin
        if (err) begin
          res_status = rde_pkg::ST_ERROR;
        end else if (empty) begin
          res_status = rde_pkg::ST_EMPTY_READ;
        end else begin
          re         = 1'b1;
          read_hit   = 1'b1;
          count_next = count - CW'(1);
          if (!reversed) begin
            head_next = head_inc;
          end
        end
      end
      default: begin
        // undefined codes do nothing
      end
    endcase
  end

  assign stat.out_free = !rsp_valid || rsp.ready;
  assign stat.read_hit = read_hit;

  // element memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.accept && we) begin
      mem[slot_back] <= value[STOREW-1:0];
    end
    if (cmd.accept && re) begin
      rd_data <= mem[reversed ? slot_last : head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      reversed <= 1'b0;
      err      <= 1'b0;
    end else if (cmd.accept) begin
      head     <= head_next;
      count    <= count_next;
      reversed <= reversed_next;
      err      <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      last_pend <= (count == CW'(1));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((cmd.accept && !read_hit) || cmd.fetch) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rsp_data   <= rde_pkg::FIELD_W'(rd_data);
      rsp_dv     <= 1'b1;
      rsp_last   <= last_pend;
      rsp_status <= rde_pkg::ST_OK;
    end else if (cmd.accept && !read_hit) begin
      rsp_data   <= '0;
      rsp_dv     <= 1'b0;
      rsp_last   <= 1'b0;
      rsp_status <= res_status;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.data       = rsp_data;
  assign rsp.data_valid = rsp_dv;
  assign rsp.last       = rsp_last;
  assign rsp.status     = rsp_status;

endmodule
